FILE: hw/rtl/rwtq_pkg.sv
// Package for the rolling window threshold qualifier.
// Holds the window size, derived widths, item and register codes and the result type.
// Has no dependencies.
package rwtq_pkg;

	localparam int WINDOW = 32;
	localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int OUT_CNT_W = 6;
	localparam int THR_W = 9;
	localparam int MIN_W = 6;
	localparam int CFG_DATA_W = 9;
	localparam int CFG_IDX_W = 1;
	localparam int CMP_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;
	localparam int PROD_W = THR_W + CNT_W;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 1'b0,
		REG_MIN_SAMPLES = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic qualified;
		logic changed;
		logic [CNT_W-1:0] ones;
		logic [CNT_W-1:0] filled;
	} result_t;

endpackage

FILE: hw/rtl/rolling_window_threshold_qualifier.sv
// Top level of the rolling window threshold qualifier: request pipeline, ring and output register.
// Depends on rwtq_pkg, rwtq_ring and rwtq_core.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall    operation, sample
//   out      output     out_valid/out_stall  qualified, changed, ones_count, filled
//   cfg      input      cfg_write            cfg_index, cfg_data
//
// One request per cycle is sustained while the output is not stalled.
// The read stage reads the old ring bit from the memory; on commit the counts and output register update.
// A write at commit to the entry being read is forwarded.
// Reset needs no clearing pass: the fill count tells which ring entries hold samples.
// A stalled output holds the pending request in the read stage and stalls the input.
module rolling_window_threshold_qualifier (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            operation,
	input  logic                            sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            qualified,
	output logic                            changed,
	output logic [rwtq_pkg::OUT_CNT_W-1:0]  ones_count,
	output logic [rwtq_pkg::OUT_CNT_W-1:0]  filled,
	input  logic                            cfg_write,
	input  logic [rwtq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rwtq_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic                       valid_s1;
	logic                       op_s1;
	logic                       sample_s1;
	logic [rwtq_pkg::PTR_W-1:0] addr_s1;
	logic                       fwd_s1;
	logic                       fwd_bit_s1;
	logic [rwtq_pkg::PTR_W-1:0] ptr_q;

	logic                   out_valid_q;
	logic                   qualified_q;
	logic                   changed_q;
	logic [rwtq_pkg::CNT_W-1:0] ones_q;
	logic [rwtq_pkg::CNT_W-1:0] filled_q;

	logic                   advance;
	logic                   commit;
	logic                   accept;
	logic                   is_sample;
	logic                   ring_bit;
	logic                   old_raw;
	rwtq_pkg::result_t      result;

	assign advance = !out_valid_q || !out_stall;
	assign commit = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign accept = in_valid && !in_stall;
	assign is_sample = (operation == rwtq_pkg::OP_SAMPLE);
	assign old_raw = fwd_s1 ? fwd_bit_s1 : ring_bit;

	rwtq_ring u_ring (
		.clk     (clk),
		.wr_en   (commit && op_s1 == rwtq_pkg::OP_SAMPLE),
		.wr_addr (addr_s1),
		.wr_bit  (sample_s1),
		.rd_en   (accept && is_sample),
		.rd_addr (ptr_q),
		.rd_bit  (ring_bit)
	);

	rwtq_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.commit    (commit),
		.op        (op_s1),
		.sample    (sample_s1),
		.old_raw   (old_raw),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ptr_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (!is_sample) begin
					ptr_q <= '0;
				end else if (ptr_q == rwtq_pkg::PTR_W'(rwtq_pkg::WINDOW - 1)) begin
					ptr_q <= '0;
				end else begin
					ptr_q <= ptr_q + rwtq_pkg::PTR_W'(1);
				end
			end else if (commit) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= operation;
			sample_s1 <= sample;
			addr_s1 <= ptr_q;
			fwd_s1 <= commit && (op_s1 == rwtq_pkg::OP_SAMPLE) && (addr_s1 == ptr_q);
			fwd_bit_s1 <= sample_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			qualified_q <= result.qualified;
			changed_q <= result.changed;
			ones_q <= result.ones;
			filled_q <= result.filled;
		end
	end

	assign out_valid = out_valid_q;
	assign qualified = qualified_q;
	assign changed = changed_q;
	assign ones_count = rwtq_pkg::OUT_CNT_W'(ones_q);
	assign filled = rwtq_pkg::OUT_CNT_W'(filled_q);

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("committed request did not reach the output register");

	a_stall_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a held request");

	a_ones_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (ones_q <= filled_q)
			&& (filled_q <= rwtq_pkg::CNT_W'(rwtq_pkg::WINDOW)))
		else $error("ones count exceeds fill count or window");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit && op_s1 == rwtq_pkg::OP_CLEAR |=> filled_q == '0 && ones_q == '0 && !qualified_q)
		else $error("clear request did not empty the counts and state");

endmodule

FILE: hw/rtl/rwtq_ring.sv
// Sample ring memory: one bit per entry, one write port and one registered read port.
// Depends on rwtq_pkg for the window depth and pointer width.
module rwtq_ring (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [rwtq_pkg::PTR_W-1:0] wr_addr,
	input  logic                      wr_bit,
	input  logic                      rd_en,
	input  logic [rwtq_pkg::PTR_W-1:0] rd_addr,
	output logic                      rd_bit
);

	logic mem [rwtq_pkg::WINDOW];
	logic rd_bit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_bit_q <= mem[rd_addr];
		end
	end

	assign rd_bit = rd_bit_q;

endmodule

FILE: hw/rtl/rwtq_core.sv
// Count and decision logic: ones count, fill count, qualified state and the two registers.
// Depends on rwtq_pkg; the old ring bit comes from rwtq_ring through the top level.
module rwtq_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [rwtq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rwtq_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           commit,
	input  logic                           op,
	input  logic                           sample,
	input  logic                           old_raw,
	output rwtq_pkg::result_t              result
);

	logic [rwtq_pkg::THR_W-1:0] threshold_q;
	logic [rwtq_pkg::MIN_W-1:0] min_q;
	logic [rwtq_pkg::CNT_W-1:0] fill_q;
	logic [rwtq_pkg::CNT_W-1:0] ones_q;
	logic                       state_q;

	logic                        full;
	logic                        old_bit;
	logic [rwtq_pkg::CNT_W-1:0]  ones_nx;
	logic [rwtq_pkg::CNT_W-1:0]  fill_nx;
	logic [rwtq_pkg::CMP_W-1:0]  need;
	logic [rwtq_pkg::PROD_W-1:0] lhs;
	logic [rwtq_pkg::PROD_W-1:0] rhs;
	logic                        state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= rwtq_pkg::THR_W'(179);
			min_q <= rwtq_pkg::MIN_W'(5);
		end else if (cfg_write) begin
			case (cfg_index)
				rwtq_pkg::REG_THRESHOLD: threshold_q <= rwtq_pkg::THR_W'(cfg_data);
				rwtq_pkg::REG_MIN_SAMPLES: min_q <= rwtq_pkg::MIN_W'(cfg_data);
				default: ;
			endcase
		end
	end

	always_comb begin
		full = (fill_q == rwtq_pkg::CNT_W'(rwtq_pkg::WINDOW));
		old_bit = full & old_raw;
		ones_nx = ones_q - rwtq_pkg::CNT_W'(old_bit) + rwtq_pkg::CNT_W'(sample);
		fill_nx = full ? fill_q : fill_q + rwtq_pkg::CNT_W'(1);
		if (rwtq_pkg::CMP_W'(min_q) > rwtq_pkg::CMP_W'(rwtq_pkg::WINDOW)) begin
			need = rwtq_pkg::CMP_W'(rwtq_pkg::WINDOW);
		end else begin
			need = rwtq_pkg::CMP_W'(min_q);
		end
		lhs = rwtq_pkg::PROD_W'(ones_nx) << 8;
		rhs = rwtq_pkg::PROD_W'(threshold_q) * rwtq_pkg::PROD_W'(fill_nx);
		if (op == rwtq_pkg::OP_CLEAR) begin
			state_nx = 1'b0;
		end else if (rwtq_pkg::CMP_W'(fill_nx) >= need) begin
			state_nx = (lhs >= rhs);
		end else if (fill_nx == rwtq_pkg::CNT_W'(1) && sample) begin
			state_nx = 1'b1;
		end else begin
			state_nx = state_q;
		end
		result.qualified = state_nx;
		result.changed = state_nx ^ state_q;
		result.ones = (op == rwtq_pkg::OP_CLEAR) ? '0 : ones_nx;
		result.filled = (op == rwtq_pkg::OP_CLEAR) ? '0 : fill_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ones_q <= '0;
			state_q <= 1'b0;
		end else if (commit) begin
			fill_q <= result.filled;
			ones_q <= result.ones;
			state_q <= result.qualified;
		end
	end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the rolling window threshold qualifier.
// Drives sample and clear requests and register writes; checks results by predictor or fixed row.
// Depends on rwtq_pkg and rolling_window_threshold_qualifier.
module tb_top;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;
	localparam int CHUNK_ITEMS = 40;
	localparam int HOLD_CYCLES = 60;

	typedef enum logic {
		ROW_ITEM = 1'b0,
		ROW_WRITE = 1'b1
	} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		rwtq_pkg::op_t op;
		logic smp;
		rwtq_pkg::reg_idx_t idx;
		logic [rwtq_pkg::CFG_DATA_W-1:0] data;
		logic known;
		rwtq_pkg::result_t exp;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	rwtq_pkg::op_t operation = rwtq_pkg::OP_SAMPLE;
	logic sample = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic qualified;
	logic changed;
	logic [rwtq_pkg::OUT_CNT_W-1:0] ones_count;
	logic [rwtq_pkg::OUT_CNT_W-1:0] filled;
	logic cfg_write = 1'b0;
	rwtq_pkg::reg_idx_t cfg_index = rwtq_pkg::REG_THRESHOLD;
	logic [rwtq_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic row_known = 1'b0;
	rwtq_pkg::result_t row_exp = '0;

	logic [rwtq_pkg::WINDOW-1:0] win_bits;
	int unsigned win_ptr;
	int unsigned win_fill;
	int unsigned win_ones;
	int unsigned thr_q8;
	int unsigned min_need;
	logic win_state;

	rwtq_pkg::result_t readings_due[$];
	int errors = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_len = 0;

	rolling_window_threshold_qualifier uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.qualified(qualified),
		.changed(changed),
		.ones_count(ones_count),
		.filled(filled),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	task automatic note_error(input string msg);
		errors++;
		if (errors <= REPORT_LIMIT) begin
			$display("%s", msg);
		end
	endtask

	function automatic void clear_window();
		win_bits = '0;
		win_ptr = 0;
		win_fill = 0;
		win_ones = 0;
		win_state = 1'b0;
	endfunction

	function automatic rwtq_pkg::result_t predict_reading(input rwtq_pkg::op_t op,
			input logic smp);
		rwtq_pkg::result_t r;
		logic was;
		int unsigned need;
		was = win_state;
		need = (min_need < rwtq_pkg::WINDOW) ? min_need : rwtq_pkg::WINDOW;
		if (op == rwtq_pkg::OP_CLEAR) begin
			clear_window();
		end else begin
			win_ones = win_ones - win_bits[win_ptr] + smp;
			win_bits[win_ptr] = smp;
			if (win_fill < rwtq_pkg::WINDOW) begin
				win_fill++;
			end
			win_ptr = (win_ptr + 1) % rwtq_pkg::WINDOW;
			if (win_fill >= need) begin
				win_state = (win_ones * 256 >= thr_q8 * win_fill);
			end else if (win_fill == 1 && smp) begin
				win_state = 1'b1;
			end
		end
		r.qualified = win_state;
		r.changed = (win_state != was);
		r.ones = win_ones[rwtq_pkg::CNT_W-1:0];
		r.filled = win_fill[rwtq_pkg::CNT_W-1:0];
		return r;
	endfunction

	function automatic stim_row_t item_row(input rwtq_pkg::op_t op, input logic smp);
		stim_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.op = op;
		r.smp = smp;
		return r;
	endfunction

	function automatic stim_row_t known_row(input rwtq_pkg::op_t op, input logic smp,
			input logic q, input logic c, input int o, input int f);
		stim_row_t r;
		r = item_row(op, smp);
		r.known = 1'b1;
		r.exp.qualified = q;
		r.exp.changed = c;
		r.exp.ones = rwtq_pkg::CNT_W'(o);
		r.exp.filled = rwtq_pkg::CNT_W'(f);
		return r;
	endfunction

	function automatic stim_row_t write_row(input rwtq_pkg::reg_idx_t idx,
			input int unsigned data);
		stim_row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.data = rwtq_pkg::CFG_DATA_W'(data);
		return r;
	endfunction

	task automatic send_request(input rwtq_pkg::op_t op, input logic smp, input logic known,
			input rwtq_pkg::result_t exp);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		sample <= smp;
		row_known <= known;
		row_exp <= exp;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (readings_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (3) @(negedge clk);
	endtask

	task automatic write_register(input rwtq_pkg::reg_idx_t idx,
			input logic [rwtq_pkg::CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_random(input int ones_pct);
		rwtq_pkg::op_t op;
		op = ($urandom_range(99) < 3) ? rwtq_pkg::OP_CLEAR : rwtq_pkg::OP_SAMPLE;
		send_request(op, ($urandom_range(99) < ones_pct), 1'b0, '0);
	endtask

	always @(posedge clk) begin : result_monitor
		rwtq_pkg::result_t got;
		rwtq_pkg::result_t want;
		if (arst_n) begin
			if (cfg_write) begin
				case (cfg_index)
					rwtq_pkg::REG_THRESHOLD: thr_q8 = cfg_data;
					rwtq_pkg::REG_MIN_SAMPLES: min_need = cfg_data[rwtq_pkg::MIN_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = {qualified, changed, ones_count, filled};
				if (readings_due.size() == 0) begin
					note_error($sformatf("unexpected result q=%b c=%b ones=%0d filled=%0d",
						got.qualified, got.changed, got.ones, got.filled));
				end else begin
					want = readings_due.pop_front();
					if (got.qualified !== want.qualified || got.changed !== want.changed ||
							got.ones !== want.ones || got.filled !== want.filled) begin
						note_error($sformatf({"mismatch: expected q=%b c=%b ones=%0d ",
							"filled=%0d, got q=%b c=%b ones=%0d filled=%0d"},
							want.qualified, want.changed, want.ones, want.filled,
							got.qualified, got.changed, got.ones, got.filled));
					end
				end
			end
			if (in_valid && !in_stall) begin
				want = predict_reading(operation, sample);
				if (row_known) begin
					want = row_exp;
				end
				readings_due.push_back(want);
			end
		end
	end

	always @(negedge clk) begin
		if (hold_len > 0) begin
			out_stall <= 1'b1;
			hold_len--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", quiet_cycles);
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		int ones_pct;
		int unsigned thr_pick;
		int unsigned min_pick;
		thr_q8 = 179;
		min_need = 5;
		clear_window();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The rows cover clears with the state low and high, the first-sample rule, a minimum
		// of zero, thresholds of zero, 256 and 511, and minimums above the window size.
		rows.push_back(known_row(rwtq_pkg::OP_CLEAR, 1'b1, 1'b0, 1'b0, 0, 0));
		rows.push_back(known_row(rwtq_pkg::OP_SAMPLE, 1'b1, 1'b1, 1'b1, 1, 1));
		repeat (4) rows.push_back(item_row(rwtq_pkg::OP_SAMPLE, 1'b0));
		rows.push_back(item_row(rwtq_pkg::OP_SAMPLE, 1'b1));
		rows.push_back(known_row(rwtq_pkg::OP_CLEAR, 1'b0, 1'b0, 1'b0, 0, 0));
		rows.push_back(write_row(rwtq_pkg::REG_MIN_SAMPLES, 0));
		rows.push_back(write_row(rwtq_pkg::REG_THRESHOLD, 0));
		rows.push_back(known_row(rwtq_pkg::OP_SAMPLE, 1'b0, 1'b1, 1'b1, 0, 1));
		rows.push_back(known_row(rwtq_pkg::OP_SAMPLE, 1'b1, 1'b1, 1'b0, 1, 2));
		rows.push_back(write_row(rwtq_pkg::REG_THRESHOLD, 511));
		rows.push_back(known_row(rwtq_pkg::OP_SAMPLE, 1'b1, 1'b0, 1'b1, 2, 3));
		rows.push_back(write_row(rwtq_pkg::REG_THRESHOLD, 256));
		rows.push_back(write_row(rwtq_pkg::REG_MIN_SAMPLES, 9'h1FF));
		rows.push_back(known_row(rwtq_pkg::OP_CLEAR, 1'b0, 1'b0, 1'b0, 0, 0));
		rows.push_back(known_row(rwtq_pkg::OP_SAMPLE, 1'b1, 1'b1, 1'b1, 1, 1));
		rows.push_back(item_row(rwtq_pkg::OP_SAMPLE, 1'b1));
		rows.push_back(item_row(rwtq_pkg::OP_SAMPLE, 1'b1));
		rows.push_back(item_row(rwtq_pkg::OP_SAMPLE, 1'b0));
		rows.push_back(write_row(rwtq_pkg::REG_MIN_SAMPLES, 40));
		rows.push_back(item_row(rwtq_pkg::OP_SAMPLE, 1'b1));
		rows.push_back(known_row(rwtq_pkg::OP_CLEAR, 1'b0, 1'b0, 1'b1, 0, 0));
		rows.push_back(write_row(rwtq_pkg::REG_THRESHOLD, 179));
		rows.push_back(write_row(rwtq_pkg::REG_MIN_SAMPLES, 5));
		rows.push_back(known_row(rwtq_pkg::OP_SAMPLE, 1'b1, 1'b1, 1'b1, 1, 1));

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_WRITE) begin
				wait_idle();
				write_register(rows[i].idx, rows[i].data);
			end else begin
				send_request(rows[i].op, rows[i].smp, rows[i].known, rows[i].exp);
			end
		end
		wait_idle();

		// The output holds off while requests keep coming, so the block fills and stalls its input.
		@(posedge clk);
		hold_len = HOLD_CYCLES;
		@(negedge clk);
		repeat (20) send_random(50);
		wait_idle();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 85; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 85; end
				default: begin send_idle_pct = 25; stall_pct = 25; end
			endcase
			for (int ch = 0; ch < 4; ch++) begin
				wait_idle();
				case ($urandom_range(5))
					0: thr_pick = 0;
					1: thr_pick = 256;
					2: thr_pick = 511;
					3: thr_pick = 179;
					4: thr_pick = $urandom_range(120, 240);
					default: thr_pick = $urandom_range(511);
				endcase
				case ($urandom_range(4))
					0: min_pick = 0;
					1: min_pick = rwtq_pkg::WINDOW;
					2: min_pick = $urandom_range(33, 63);
					default: min_pick = $urandom_range(1, 8);
				endcase
				write_register(rwtq_pkg::REG_THRESHOLD, rwtq_pkg::CFG_DATA_W'(thr_pick));
				write_register(rwtq_pkg::REG_MIN_SAMPLES,
					rwtq_pkg::CFG_DATA_W'(($urandom_range(7) << rwtq_pkg::MIN_W) | min_pick));
				case ($urandom_range(4))
					0: ones_pct = 5;
					1: ones_pct = 50;
					2: ones_pct = 95;
					3: ones_pct = 70;
					default: ones_pct = $urandom_range(100);
				endcase
				repeat (CHUNK_ITEMS) send_random(ones_pct);
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (readings_due.size() != 0) begin
			note_error($sformatf("%0d results never arrived", readings_due.size()));
		end
		if (errors == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
